>>> hdl/cft_pkg.sv
// shared types, constants and helpers of the csv field tokenizer
// no dependencies; used by every module of the block

package cft_pkg;

	// default width of the column and field length counters
	localparam int COUNT_BITS_DEFAULT = 16;

	// entries of the event queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// fixed byte codes
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_CR  = 8'h0D;
	localparam logic [7:0] BYTE_BSL = 8'h5C;
	localparam logic [7:0] BYTE_SP  = 8'h20;
	localparam logic [7:0] BYTE_TAB = 8'h09;

	// register reset values
	localparam logic [7:0] SEP_RESET   = 8'd59;
	localparam logic [7:0] QUOTE_RESET = 8'd34;

	// register indexes
	localparam logic [1:0] REG_SEP   = 2'd0;
	localparam logic [1:0] REG_QUOTE = 2'd1;
	localparam logic [1:0] REG_QEN   = 2'd2;
	localparam logic [1:0] REG_BSEN  = 2'd3;

	typedef enum logic [1:0] {
		EV_ROW  = 2'd0,
		EV_DATA = 2'd1,
		EV_FEND = 2'd2,
		EV_REND = 2'd3
	} ev_kind_t;

	typedef struct packed {
		logic [7:0] sep_char;
		logic [7:0] quote_char;
		logic       quote_enable;
		logic       backslash_enable;
	} cfg_t;

	// what one byte produces: an optional row begin and an optional main event
	typedef struct packed {
		logic        has_row;
		logic [15:0] row_col;
		logic        has_main;
		ev_kind_t    kind;
		logic [7:0]  data;
		logic [31:0] row;
		logic [15:0] col;
		logic [15:0] len;
		logic        quoted;
	} bundle_t;

	function automatic logic [15:0] clip16(input logic [31:0] v);
		return (|v[31:16]) ? 16'hFFFF : v[15:0];
	endfunction

endpackage

>>> hdl/cft_front.sv
// front end: parse state machine, row/column/length counters, event bundles
// depends on cft_pkg

module cft_front #(
	parameter int COUNT_BITS = cft_pkg::COUNT_BITS_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cft_pkg::cfg_t    cfg,
	input  logic             in_valid,
	input  logic [7:0]       in_byte,
	output logic             in_ready,
	output logic             push_valid,
	output cft_pkg::bundle_t push_data,
	input  logic             push_ready
);

	typedef enum logic [8:0] {
		ST_BOL    = 9'b000000001,
		ST_BOL_CR = 9'b000000010,
		ST_BOF    = 9'b000000100,
		ST_DROP   = 9'b000001000,
		ST_PLAIN  = 9'b000010000,
		ST_QUOTED = 9'b000100000,
		ST_QCLOSE = 9'b001000000,
		ST_QBACK  = 9'b010000000,
		ST_AFTERQ = 9'b100000000
	} state_t;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	state_t                state_q, st, nxt;
	logic [31:0]           row_q, row_n;
	logic [COUNT_BITS-1:0] col_q, col_n;
	logic [COUNT_BITS-1:0] len_q, len_n;
	logic                  run;
	logic                  is_sep, is_brk;
	cft_pkg::bundle_t      ev;
	logic                  accept;

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;
	assign is_sep   = (in_byte == cfg.sep_char);
	assign is_brk   = is_sep || (in_byte == cft_pkg::BYTE_CR) || (in_byte == cft_pkg::BYTE_LF);

	always_comb begin
		st    = state_q;
		nxt   = state_q;
		row_n = row_q;
		col_n = col_q;
		len_n = len_q;
		run   = 1'b1;
		ev    = '0;
		ev.row = row_q;

		// cr seen: swallow a following lf, else start the next row
		if (st == ST_BOL_CR) begin
			nxt = ST_BOL;
			if (in_byte == cft_pkg::BYTE_LF) begin
				run = 1'b0;
			end else begin
				st = ST_BOL;
			end
		end

		// begin of line or unknown state
		if (run) begin
			case (st)
				ST_BOF, ST_DROP, ST_PLAIN, ST_QUOTED, ST_QCLOSE, ST_QBACK, ST_AFTERQ: begin
				end
				default: begin
					ev.has_row = 1'b1;
					ev.row_col = cft_pkg::clip16(32'(col_q));
					col_n      = '0;
					st         = ST_BOF;
				end
			endcase
		end

		// begin of field
		if (run && st == ST_BOF) begin
			len_n = '0;
			if (cfg.quote_enable && in_byte == cfg.quote_char) begin
				nxt = ST_QUOTED;
				run = 1'b0;
			end else begin
				st = ST_PLAIN;
			end
		end

		ev.col = cft_pkg::clip16(32'(col_n));

		// closing quote or backslash: literal byte or fall to after-quote
		if (run && (st == ST_QCLOSE || st == ST_QBACK)) begin
			if (in_byte == cfg.quote_char ||
			    (st == ST_QBACK && in_byte == cft_pkg::BYTE_BSL)) begin
				ev.has_main = 1'b1;
				ev.kind     = cft_pkg::EV_DATA;
				ev.data     = in_byte;
				len_n       = (len_n == CNT_MAX) ? len_n : len_n + 1'b1;
				nxt         = ST_QUOTED;
				run         = 1'b0;
			end else begin
				st = ST_AFTERQ;
			end
		end

		if (run) begin
			nxt = st;
			case (st)
				ST_PLAIN, ST_AFTERQ: begin
					if (st == ST_AFTERQ &&
					    (in_byte == cft_pkg::BYTE_SP || in_byte == cft_pkg::BYTE_TAB)) begin
						nxt = ST_AFTERQ;
					end else if (is_brk) begin
						ev.has_main = 1'b1;
						ev.len      = cft_pkg::clip16(32'(len_n));
						ev.quoted   = (st == ST_AFTERQ);
						if (is_sep) begin
							ev.kind = cft_pkg::EV_FEND;
							col_n   = (col_n == CNT_MAX) ? col_n : col_n + 1'b1;
							nxt     = ST_BOF;
						end else begin
							ev.kind = cft_pkg::EV_REND;
							row_n   = (&row_q) ? row_q : row_q + 32'd1;
							nxt     = (in_byte == cft_pkg::BYTE_CR) ? ST_BOL_CR : ST_BOL;
						end
					end else if (st == ST_AFTERQ) begin
						nxt = ST_DROP;
					end else begin
						ev.has_main = 1'b1;
						ev.kind     = cft_pkg::EV_DATA;
						ev.data     = in_byte;
						len_n       = (len_n == CNT_MAX) ? len_n : len_n + 1'b1;
					end
				end
				ST_DROP: begin
					if (is_sep) begin
						nxt = ST_BOF;
					end else if (in_byte == cft_pkg::BYTE_LF) begin
						row_n = (&row_q) ? row_q : row_q + 32'd1;
						nxt   = ST_BOL;
					end
				end
				ST_QUOTED: begin
					if (cfg.backslash_enable && in_byte == cft_pkg::BYTE_BSL) begin
						nxt = ST_QBACK;
					end else if (in_byte == cfg.quote_char) begin
						nxt = ST_QCLOSE;
					end else begin
						ev.has_main = 1'b1;
						ev.kind     = cft_pkg::EV_DATA;
						ev.data     = in_byte;
						len_n       = (len_n == CNT_MAX) ? len_n : len_n + 1'b1;
					end
				end
				default: begin
					nxt = ST_BOL;
				end
			endcase
		end
	end

	assign push_valid = accept && (ev.has_row || ev.has_main);
	assign push_data  = ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BOL;
			row_q   <= '0;
			col_q   <= '0;
			len_q   <= '0;
		end else if (accept) begin
			state_q <= nxt;
			row_q   <= row_n;
			col_q   <= col_n;
			len_q   <= len_n;
		end
	end

endmodule

>>> hdl/cft_queue.sv
// short register queue of event bundles between front and back
// depends on cft_pkg

module cft_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  cft_pkg::bundle_t push_data,
	output logic             push_ready,
	output logic             pop_valid,
	output cft_pkg::bundle_t pop_data,
	input  logic             pop_ready
);

	localparam int DEPTH = cft_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cft_pkg::bundle_t  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push, do_pop;

	assign push_ready = (cnt_q != CNT_FULL);
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/cft_back.sv
// back end: splits bundles into single events and holds the output register
// depends on cft_pkg

module cft_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	input  cft_pkg::bundle_t pop_data,
	output logic             pop_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       event_kind,
	output logic [7:0]       data_byte,
	output logic [31:0]      row_index,
	output logic [15:0]      column_index,
	output logic [15:0]      field_length,
	output logic             was_quoted,
	output logic             last
);

	logic        valid_q, phase_q, load, row_part;
	logic [1:0]  kind_q;
	logic [7:0]  data_q;
	logic [31:0] row_q;
	logic [15:0] col_q, len_q;
	logic        quoted_q, last_q;

	assign load      = !valid_q || out_ready;
	// row begin still owed for the head bundle
	assign row_part  = pop_data.has_row && !phase_q;
	assign pop_ready = load && (!row_part || !pop_data.has_main);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= pop_valid;
			if (pop_valid) begin
				phase_q <= row_part && pop_data.has_main;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && pop_valid) begin
			row_q <= pop_data.row;
			if (row_part) begin
				kind_q   <= cft_pkg::EV_ROW;
				data_q   <= '0;
				col_q    <= pop_data.row_col;
				len_q    <= '0;
				quoted_q <= 1'b0;
				last_q   <= !pop_data.has_main;
			end else begin
				kind_q   <= pop_data.kind;
				data_q   <= pop_data.data;
				col_q    <= pop_data.col;
				len_q    <= pop_data.len;
				quoted_q <= pop_data.quoted;
				last_q   <= 1'b1;
			end
		end
	end

	assign out_valid    = valid_q;
	assign event_kind   = kind_q;
	assign data_byte    = data_q;
	assign row_index    = row_q;
	assign column_index = col_q;
	assign field_length = len_q;
	assign was_quoted   = quoted_q;
	assign last         = last_q;

endmodule

>>> hdl/csv_field_tokenizer_core.sv
// top level of the csv field tokenizer: register port, front, queue, back
// depends on cft_pkg, cft_front, cft_queue, cft_back

// The tokenizer takes one byte of CSV text per cycle on the s_ stream and
// reports events on the m_ stream: row begin, field data byte, field end and
// record end, each with row, column, field length and a quoted flag; m_tlast
// marks the last event caused by a byte. A byte is accepted every cycle as
// long as the four-entry event queue has room; the parse state and counters
// update in the same cycle in the front end. The back end sends one event per
// cycle while m_tready is high, so a byte at the start of a row (row begin plus
// its first event) can yield two events, which the queue absorbs. The events
// of a byte pass the queue and then the output register. Separator, quote
// character and the quote and backslash enables sit in APB registers at 0x0,
// 0x4, 0x8 and 0xC and should only be changed while the block is idle.

module csv_field_tokenizer_core #(
	parameter int COUNT_BITS = cft_pkg::COUNT_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte[7:0]
	// event stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // data_byte[7:0], row_index[39:8], column_index[55:40],
	                               // field_length[71:56], was_quoted[72], zero[79:73]
	output logic [1:0]  m_tuser,   // event_kind[1:0]
	output logic        m_tlast
);

	cft_pkg::cfg_t    cfg_q;
	logic             wr_en;
	logic [1:0]       reg_idx;

	logic             push_valid, push_ready, pop_valid, pop_ready;
	cft_pkg::bundle_t push_data, pop_data;

	logic [1:0]       event_kind;
	logic [7:0]       data_byte;
	logic [31:0]      row_index;
	logic [15:0]      column_index, field_length;
	logic             was_quoted, last;

	// register port: write in the access phase, no wait states
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sep_char         <= cft_pkg::SEP_RESET;
			cfg_q.quote_char       <= cft_pkg::QUOTE_RESET;
			cfg_q.quote_enable     <= 1'b1;
			cfg_q.backslash_enable <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				cft_pkg::REG_SEP:   cfg_q.sep_char         <= pwdata[7:0];
				cft_pkg::REG_QUOTE: cfg_q.quote_char       <= pwdata[7:0];
				cft_pkg::REG_QEN:   cfg_q.quote_enable     <= pwdata[0];
				cft_pkg::REG_BSEN:  cfg_q.backslash_enable <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_idx)
			cft_pkg::REG_SEP:   prdata = {24'd0, cfg_q.sep_char};
			cft_pkg::REG_QUOTE: prdata = {24'd0, cfg_q.quote_char};
			cft_pkg::REG_QEN:   prdata = {31'd0, cfg_q.quote_enable};
			cft_pkg::REG_BSEN:  prdata = {31'd0, cfg_q.backslash_enable};
			default:            prdata = '0;
		endcase
	end

	// front: parse state and counters, one byte per cycle while the queue has room
	cft_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_byte    (s_tdata),
		.in_ready   (s_tready),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	// event bundles waiting for the output side
	cft_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	// back: one event per cycle into the output register while m_tready allows
	cft_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_data     (pop_data),
		.pop_ready    (pop_ready),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.event_kind   (event_kind),
		.data_byte    (data_byte),
		.row_index    (row_index),
		.column_index (column_index),
		.field_length (field_length),
		.was_quoted   (was_quoted),
		.last         (last)
	);

	assign m_tdata = {7'd0, was_quoted, field_length, column_index, row_index, data_byte};
	assign m_tuser = event_kind;
	assign m_tlast = last;

endmodule
